// ===== hw/rtl/cfl_pkg.sv =====
`timescale 1ns / 1ps

package cfl_pkg;

    localparam int CFL_W   = 18;
    localparam int GRAV_W  = 24;
    localparam int CELL_W  = 32;
    localparam int H_W     = 24;
    localparam int MOM_W   = 24;
    localparam int STEP_W  = 32;
    localparam int FRAC_W  = 16;

    // shared serial multiplier: 32 x 24
    localparam int MUL_AW  = 32;
    localparam int MUL_BW  = 24;
    localparam int MUL_PW  = MUL_AW + MUL_BW;

    // shared square root: 48-bit radicand, 24-bit root
    localparam int SQ_W    = 48;
    localparam int SQ_RW   = SQ_W / 2;

    // shared divider: 50-bit dividend, 41-bit divisor
    localparam int DIV_NW  = 50;
    localparam int DIV_DW  = 41;

    localparam int T1_W    = 40;
    localparam int CFG_IW  = 2;
    localparam int CFG_DW  = 24;

    localparam logic [CFG_IW-1:0] CFG_CFL     = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_GRAVITY = 2'd1;

    localparam logic [CFL_W-1:0]  CFL_RESET  = 18'd52429;
    localparam logic [GRAV_W-1:0] GRAV_RESET = 24'd642690;
    localparam logic [STEP_W-1:0] STEP_MAX   = '1;

    typedef struct packed {
        logic [CELL_W-1:0]       cell_size;
        logic [H_W-1:0]          water_height;
        logic signed [MOM_W-1:0] momentum_x;
        logic signed [MOM_W-1:0] momentum_y;
        logic                    end_of_pass;
    } cfl_in_t;

    typedef struct packed {
        logic [STEP_W-1:0] min_time_step;
        logic              dry_point_seen;
    } cfl_out_t;

    typedef struct packed {
        logic start;
        logic done;
    } unit_ctl_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQX,
        S_SQY,
        S_MAG,
        S_GH,
        S_T2,
        S_T1,
        S_NUM,
        S_STEP,
        S_EMIT
    } cfl_state_t;

endpackage

// ===== hw/rtl/cfl_mul.sv =====
`timescale 1ns / 1ps

module cfl_mul
    import cfl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [MUL_AW-1:0] a,
    input  logic [MUL_BW-1:0] b,
    output logic              done,
    output logic [MUL_PW-1:0] prod
);

    localparam int CW = $clog2(MUL_BW + 1);

    logic [MUL_PW-1:0] a_reg;
    logic [MUL_BW-1:0] b_reg;
    logic [MUL_PW-1:0] p_reg;
    logic [CW-1:0]     cnt_reg;
    logic              done_reg;

    // shift-add, one multiplier bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
                cnt_reg <= CW'(MUL_BW);
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                    done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= MUL_PW'(a);
            b_reg <= b;
            p_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            if (b_reg[0])
                p_reg <= p_reg + a_reg;
            a_reg <= {a_reg[MUL_PW-2:0], 1'b0};
            b_reg <= {1'b0, b_reg[MUL_BW-1:1]};
        end
    end

    assign done = done_reg;
    assign prod = p_reg;

endmodule

// ===== hw/rtl/cfl_sqrt.sv =====
`timescale 1ns / 1ps

module cfl_sqrt
    import cfl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [SQ_W-1:0]  rad,
    output logic             done,
    output logic [SQ_RW-1:0] root
);

    localparam int CW = $clog2(SQ_RW + 1);

    logic [SQ_W-1:0]  rad_reg;
    logic [SQ_RW:0]   rem_reg;
    logic [SQ_RW-1:0] root_reg;
    logic [CW-1:0]    cnt_reg;
    logic             done_reg;
    logic [SQ_RW+2:0] rem_t;
    logic [SQ_RW+2:0] trial;
    logic             fit;

    // restoring root, two radicand bits in and one root bit out per cycle
    assign rem_t = {rem_reg, rad_reg[SQ_W-1:SQ_W-2]};
    assign trial = {1'b0, root_reg, 2'b01};
    assign fit   = rem_t >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
                cnt_reg <= CW'(SQ_RW);
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                    done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= rad;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            rad_reg <= {rad_reg[SQ_W-3:0], 2'b00};
            if (fit)
            begin
                rem_reg  <= (SQ_RW+1)'(rem_t - trial);
                root_reg <= {root_reg[SQ_RW-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_t[SQ_RW:0];
                root_reg <= {root_reg[SQ_RW-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ===== hw/rtl/cfl_div.sv =====
`timescale 1ns / 1ps

module cfl_div
    import cfl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIV_NW-1:0] dividend,
    input  logic [DIV_DW-1:0] divisor,
    output logic              done,
    output logic [DIV_NW-1:0] quot
);

    localparam int CW = $clog2(DIV_NW + 1);

    logic [DIV_NW-1:0] q_reg;
    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_DW-1:0] dsr_reg;
    logic [CW-1:0]     cnt_reg;
    logic              done_reg;
    logic [DIV_DW:0]   rem_t;
    logic              fit;

    // restoring division, one quotient bit per cycle; a zero divisor gives all ones
    assign rem_t = {rem_reg, q_reg[DIV_NW-1]};
    assign fit   = rem_t >= {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
                cnt_reg <= CW'(DIV_NW);
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                    done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            q_reg <= {q_reg[DIV_NW-2:0], fit};
            if (fit)
                rem_reg <= DIV_DW'(rem_t - {1'b0, dsr_reg});
            else
                rem_reg <= rem_t[DIV_DW-1:0];
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

// ===== hw/rtl/cfl_time_step_min.sv =====
`timescale 1ns / 1ps

// CFL time-step minimum. Each input beat is one sample point. A wet point keeps
// in_stall high while four 24-bit multiplies, two 24-bit roots and two 50-bit
// divisions run one after another on shared bit-serial units. A dry point without
// end_of_pass does not stall. A beat with end_of_pass adds the emit state, which
// waits while an earlier output beat is still stalled, and produces one output beat
// with the pass minimum and the dry flag; the minimum then restarts at all ones.
// cfg_ready is always high; index 0 writes the Courant number, index 1 gravity,
// other indexes are ignored.
module cfl_time_step_min
    import cfl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  cfl_in_t           in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output cfl_out_t          out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [CFG_DW-1:0] cfg_data
);

    cfl_state_t state_reg, state_next;
    logic       go_reg, go_next;

    logic [CFL_W-1:0]  cfl_reg;
    logic [GRAV_W-1:0] grav_reg;
    logic [STEP_W-1:0] min_reg;
    logic              dry_reg;
    logic              out_valid_reg;
    cfl_out_t          out_reg;

    logic [CELL_W-1:0] cell_reg;
    logic [H_W-1:0]    h_reg;
    logic [MOM_W-1:0]  ax_reg;
    logic [MOM_W-1:0]  ay_reg;
    logic              last_reg;
    logic [SQ_W-1:0]   sq_reg;
    logic [SQ_RW-1:0]  mag_reg;
    logic [SQ_RW-1:0]  t2_reg;
    logic [T1_W-1:0]   t1_reg;
    logic [DIV_NW-1:0] num_reg;

    unit_ctl_t         mul_ctl, sq_ctl, div_ctl;
    logic [MUL_AW-1:0] mul_a;
    logic [MUL_BW-1:0] mul_b;
    logic [MUL_PW-1:0] mul_p;
    logic [SQ_RW-1:0]  sq_root;
    logic [DIV_NW-1:0] div_n;
    logic [DIV_DW-1:0] div_d;
    logic [DIV_NW-1:0] div_q;
    logic [DIV_DW-1:0] speed;
    logic [STEP_W-1:0] step;
    logic              in_acc;
    logic              emit;

    assign in_acc   = in_valid && !in_stall;
    assign in_stall = state_reg != S_IDLE;
    assign speed    = DIV_DW'(t1_reg) + DIV_DW'(t2_reg);
    assign step     = (div_q[DIV_NW-1:STEP_W] != '0) ? STEP_MAX : div_q[STEP_W-1:0];
    assign emit     = state_reg == S_EMIT && !(out_valid_reg && out_stall);

    // operand select for the shared units
    always_comb
    begin
        mul_a = MUL_AW'(ax_reg);
        mul_b = ax_reg;
        div_n = DIV_NW'({mag_reg, {FRAC_W{1'b0}}});
        div_d = DIV_DW'(h_reg);
        case (state_reg)
            S_SQY:
            begin
                mul_a = MUL_AW'(ay_reg);
                mul_b = ay_reg;
            end
            S_GH:
            begin
                mul_a = MUL_AW'(grav_reg);
                mul_b = h_reg;
            end
            S_NUM:
            begin
                mul_a = cell_reg;
                mul_b = MUL_BW'(cfl_reg);
            end
            S_STEP:
            begin
                div_n = num_reg;
                div_d = speed;
            end
            default:
            begin
            end
        endcase
    end

    assign mul_ctl.start = go_reg && (state_reg == S_SQX || state_reg == S_SQY ||
                                      state_reg == S_GH || state_reg == S_NUM);
    assign sq_ctl.start  = go_reg && (state_reg == S_MAG || state_reg == S_T2);
    assign div_ctl.start = go_reg && (state_reg == S_T1 || state_reg == S_STEP);

    cfl_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_ctl.start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_ctl.done),
        .prod  (mul_p)
    );

    cfl_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_ctl.start),
        .rad   (sq_reg),
        .done  (sq_ctl.done),
        .root  (sq_root)
    );

    cfl_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_ctl.start),
        .dividend (div_n),
        .divisor  (div_d),
        .done     (div_ctl.done),
        .quot     (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            go_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            go_reg    <= go_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        go_next    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (in_data.water_height != '0)
                    begin
                        state_next = S_SQX;
                        go_next    = 1'b1;
                    end
                    else if (in_data.end_of_pass)
                        state_next = S_EMIT;
                end
            end
            S_SQX:
            begin
                if (mul_ctl.done)
                begin
                    state_next = S_SQY;
                    go_next    = 1'b1;
                end
            end
            S_SQY:
            begin
                if (mul_ctl.done)
                begin
                    state_next = S_MAG;
                    go_next    = 1'b1;
                end
            end
            S_MAG:
            begin
                if (sq_ctl.done)
                begin
                    state_next = S_GH;
                    go_next    = 1'b1;
                end
            end
            S_GH:
            begin
                if (mul_ctl.done)
                begin
                    state_next = S_T2;
                    go_next    = 1'b1;
                end
            end
            S_T2:
            begin
                if (sq_ctl.done)
                begin
                    state_next = S_T1;
                    go_next    = 1'b1;
                end
            end
            S_T1:
            begin
                if (div_ctl.done)
                begin
                    state_next = S_NUM;
                    go_next    = 1'b1;
                end
            end
            S_NUM:
            begin
                if (mul_ctl.done)
                begin
                    state_next = S_STEP;
                    go_next    = 1'b1;
                end
            end
            S_STEP:
            begin
                if (div_ctl.done)
                    state_next = last_reg ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                if (emit)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // config, pass state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfl_reg       <= CFL_RESET;
            grav_reg      <= GRAV_RESET;
            min_reg       <= STEP_MAX;
            dry_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_CFL:     cfl_reg  <= cfg_data[CFL_W-1:0];
                    CFG_GRAVITY: grav_reg <= cfg_data[GRAV_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (in_acc && in_data.water_height == '0)
                dry_reg <= 1'b1;
            if (state_reg == S_STEP && div_ctl.done && step < min_reg)
                min_reg <= step;
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
                min_reg       <= STEP_MAX;
                dry_reg       <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg.min_time_step  <= min_reg;
            out_reg.dry_point_seen <= dry_reg;
        end
        if (in_acc)
        begin
            cell_reg <= in_data.cell_size;
            h_reg    <= in_data.water_height;
            ax_reg   <= in_data.momentum_x[MOM_W-1] ? MOM_W'(-in_data.momentum_x)
                                                    : MOM_W'(in_data.momentum_x);
            ay_reg   <= in_data.momentum_y[MOM_W-1] ? MOM_W'(-in_data.momentum_y)
                                                    : MOM_W'(in_data.momentum_y);
            last_reg <= in_data.end_of_pass;
        end
        case (state_reg)
            S_SQX:
                if (mul_ctl.done)
                    sq_reg <= mul_p[SQ_W-1:0];
            S_SQY:
                if (mul_ctl.done)
                    sq_reg <= sq_reg + mul_p[SQ_W-1:0];
            S_MAG:
                if (sq_ctl.done)
                    mag_reg <= sq_root;
            S_GH:
                if (mul_ctl.done)
                    sq_reg <= mul_p[SQ_W-1:0];
            S_T2:
                if (sq_ctl.done)
                    t2_reg <= sq_root;
            S_T1:
                if (div_ctl.done)
                    t1_reg <= div_q[T1_W-1:0];
            S_NUM:
                if (mul_ctl.done)
                    num_reg <= mul_p[DIV_NW-1:0];
            default:
            begin
            end
        endcase
    end

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef SYNTHESIS
    // a wet point always starts the magnitude chain
    a_wet_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && in_data.water_height != '0 |=> state_reg == S_SQX && go_reg)
        else $error("wet point did not start the arithmetic");

    // a new output beat only comes out of the emit state
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_EMIT))
        else $error("output beat without emit");

    // the pass restarts after the result is captured
    a_pass_restart: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> min_reg == STEP_MAX && !dry_reg && out_valid_reg)
        else $error("pass state not cleared on emit");

    // at most one shared unit is started at a time
    a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({mul_ctl.start, sq_ctl.start, div_ctl.start}))
        else $error("two units started together");
`endif

endmodule

// ===== sim/tb_cfl_time_step_min.sv =====
`timescale 1ns / 1ps

module tb_cfl_time_step_min;
    import cfl_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 400;
    localparam logic [CFG_IW-1:0] CFG_UNUSED = 2'd3;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    cfl_in_t           in_data;
    logic              out_valid;
    logic              out_stall;
    cfl_out_t          out_data;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CFG_IW-1:0] cfg_index;
    logic [CFG_DW-1:0] cfg_data;

    logic [CFL_W-1:0]  courant;
    logic [GRAV_W-1:0] grav;
    logic [STEP_W-1:0] pass_min;
    logic              pass_dry;
    cfl_out_t          pass_results[$];
    int                mismatches;
    int                idle_cycles;
    int                burst_left;
    bit                stall_free;

    cfl_time_step_min uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] b;
        root = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= root + b)
            begin
                v = v - (root + b);
                root = (root >> 1) + b;
            end
            else
                root = root >> 1;
            b = b >> 2;
        end
        return root;
    endfunction

    // fold one point into the pass minimum, return 1 when a pass result is due
    function automatic bit apply_point(input cfl_in_t p);
        logic [63:0] ax, ay, mag, t1, t2, speed, num, q;
        logic [STEP_W-1:0] step;
        ax = (p.momentum_x < 0) ? 64'(-64'(signed'(p.momentum_x))) : 64'(p.momentum_x);
        ay = (p.momentum_y < 0) ? 64'(-64'(signed'(p.momentum_y))) : 64'(p.momentum_y);
        if (p.water_height == 0)
            pass_dry = 1'b1;
        else
        begin
            mag = int_sqrt(ax * ax + ay * ay);
            t1 = (mag << 16) / 64'(p.water_height);
            t2 = int_sqrt(64'(grav) * 64'(p.water_height));
            speed = t1 + t2;
            num = 64'(courant) * 64'(p.cell_size);
            step = STEP_MAX;
            if (speed != 0)
            begin
                q = num / speed;
                step = (q > 64'(STEP_MAX)) ? STEP_MAX : q[STEP_W-1:0];
            end
            if (step < pass_min)
                pass_min = step;
        end
        return p.end_of_pass;
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    task automatic send_point(input cfl_in_t p);
        cfl_out_t r;
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(0, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
        in_valid <= 1'b1;
        in_data <= p;
        do
            @(posedge clk);
        while (in_stall);
        burst_left--;
        if (apply_point(p))
        begin
            r.min_time_step = pass_min;
            r.dry_point_seen = pass_dry;
            pass_results.push_back(r);
            pass_min = STEP_MAX;
            pass_dry = 1'b0;
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pass_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_CFL)
            courant = val[CFL_W-1:0];
        else if (idx == CFG_GRAVITY)
            grav = val;
    endtask

    function automatic cfl_in_t make_point(input logic [31:0] c, input logic [23:0] h,
                                          input logic [23:0] mx, input logic [23:0] my,
                                          input logic e);
        cfl_in_t p;
        p.cell_size = c;
        p.water_height = h;
        p.momentum_x = mx;
        p.momentum_y = my;
        p.end_of_pass = e;
        return p;
    endfunction

    function automatic cfl_in_t random_point(input bit mark);
        logic [31:0] c;
        logic [23:0] h;
        case ($urandom_range(0, 5))
            0: c = $urandom_range(0, 255);
            1: c = 32'hFFFF_FFFF - $urandom_range(0, 255);
            default: c = $urandom;
        endcase
        case ($urandom_range(0, 9))
            0: h = 24'd0;
            1: h = 24'($urandom_range(1, 16));
            2: h = 24'hFFFFFF - 24'($urandom_range(0, 15));
            default: h = 24'($urandom);
        endcase
        return make_point(c, h, 24'($urandom),
                          ($urandom_range(0, 3) == 0) ? 24'd0 : 24'($urandom), mark);
    endfunction

    task automatic test_directed();
        send_point(make_point(32'h0001_0000, 24'h010000, 24'd0, 24'd0, 1'b0));
        send_point(make_point(32'hFFFF_FFFF, 24'hFFFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b0));
        send_point(make_point(32'd0, 24'd1, 24'h800000, 24'h800000, 1'b1));
        // pass of dry points only
        send_point(make_point(32'd5, 24'd0, 24'd0, 24'd0, 1'b0));
        send_point(make_point(32'd7, 24'd0, 24'h123456, 24'hABCDEF, 1'b1));
        send_point(make_point(32'hFFFF_FFFF, 24'd1, 24'd0, 24'd0, 1'b1));
        send_point(make_point(32'h1234_5678, 24'h000100, 24'h800000, 24'd1, 1'b0));
        send_point(make_point(32'h0000_0001, 24'h7FFFFF, 24'hFFFFFF, 24'h000001, 1'b1));
        send_point(make_point(32'hFFFF_FFFF, 24'd0, 24'd0, 24'd0, 1'b1));
        wait_idle();
        // no gravity; the first point has no momentum and so zero wave speed
        write_reg(CFG_GRAVITY, 24'd0);
        write_reg(CFG_CFL, 24'h3FFFF);
        send_point(make_point(32'h0002_0000, 24'h010000, 24'd0, 24'd0, 1'b1));
        send_point(make_point(32'hFFFF_FFFF, 24'd1, 24'd1, 24'd0, 1'b1));
        send_point(make_point(32'hFFFF_FFFF, 24'hFFFFFF, 24'h7FFFFF, 24'd0, 1'b1));
        wait_idle();
        write_reg(CFG_UNUSED, 24'hFFFFFF);
        write_reg(CFG_CFL, 24'd0);
        write_reg(CFG_GRAVITY, 24'hFFFFFF);
        send_point(make_point(32'hFFFF_FFFF, 24'd1, 24'd5, 24'd5, 1'b1));
        send_point(make_point(32'h0001_0000, 24'hFFFFFF, 24'd0, 24'd0, 1'b1));
        wait_idle();
    endtask

    task automatic test_random_passes(input int points);
        int left;
        int len;
        left = points;
        while (left > 0)
        begin
            len = $urandom_range(1, 8);
            for (int i = 0; i < len && left > 0; i++)
            begin
                send_point(random_point(i == len - 1));
                left--;
            end
        end
        send_point(random_point(1'b1));
        wait_idle();
    endtask

    task automatic test_settings();
        logic [CFG_DW-1:0] cfl_set[4];
        logic [CFG_DW-1:0] grav_set[4];
        cfl_set = '{24'd52429, 24'h3FFFF, 24'd1, 24'd0};
        grav_set = '{24'd642690, 24'd0, 24'hFFFFFF, 24'd1};
        for (int s = 0; s < 4; s++)
        begin
            write_reg(CFG_CFL, cfl_set[s]);
            write_reg(CFG_GRAVITY, grav_set[s]);
            test_random_passes(155);
        end
        write_reg(CFG_CFL, 24'($urandom));
        write_reg(CFG_GRAVITY, 24'($urandom));
        test_random_passes(200);
    endtask

    // receiver stalls in runs, sometimes not at all
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (stall_free)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 3) == 0) ? ~out_stall : out_stall;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pass_results.size() == 0)
                report("unexpected beat", 64'(out_data), 64'd0);
            else
            begin
                if (out_data.min_time_step !== pass_results[0].min_time_step)
                    report("min_time_step", 64'(out_data.min_time_step),
                           64'(pass_results[0].min_time_step));
                if (out_data.dry_point_seen !== pass_results[0].dry_point_seen)
                    report("dry_point_seen", 64'(out_data.dry_point_seen),
                           64'(pass_results[0].dry_point_seen));
                void'(pass_results.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if ($urandom_range(0, 199) == 0)
            stall_free <= ~stall_free;
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        stall_free = 1'b0;
        idle_cycles = 0;
        mismatches = 0;
        burst_left = 0;
        courant = CFL_RESET;
        grav = GRAV_RESET;
        pass_min = STEP_MAX;
        pass_dry = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_settings();
        if (mismatches == 0 && pass_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
